FILE: rtl/hmm_pkg.sv
//------------------------------------------------------------------------------
// hmm_pkg
// shared types, function codes and state encodings of the forward filter step
//------------------------------------------------------------------------------
`default_nettype none

package hmm_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned SYM_W   = 4;
  localparam int unsigned ROW_W   = 3;
  localparam int unsigned COL_W   = 4;
  localparam int unsigned PROB_W  = 16;
  localparam int unsigned IDX_W   = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_OBSERVE = 3'd0,
    FN_WR_TRANS = 3'd1,
    FN_WR_EMIS = 3'd2,
    FN_WR_PRIOR = 3'd3,
    FN_RESTART = 3'd4
  } func_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [PROB_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  state_index;
    logic [PROB_W-1:0] probability;
    logic              last;
    logic              fell_back;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_EMIS_RD,
    ST_EMIS_MUL,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_EMIT,
    ST_RESTART
  } exec_state_t;

endpackage

`default_nettype wire

FILE: rtl/hmm_forward_filter_step.sv
//------------------------------------------------------------------------------
// hmm_forward_filter_step
// one forward-filter step of a hidden markov model in q0.16
//------------------------------------------------------------------------------
// commands enter on start/cmd and are accepted at an edge with start high and
// busy low. a two-entry queue parts the front end from the execution engine,
// so table writes are taken while an observation is still being worked on.
// an observation runs STATES*STATES multiply-accumulates through the
// transition ram (read, multiply, accumulate), one emission step per state,
// then, unless the total is zero (the belief then falls back to the prior),
// one serial restoring divide per state, then emits STATES results on
// result_valid/result, one a cycle, last marked. results cannot be held off.
// reset empties the queue and clears the belief; tables and prior are
// undefined until written.
//------------------------------------------------------------------------------
`default_nettype none

module hmm_forward_filter_step #(
  parameter int unsigned STATES  = 8,
  parameter int unsigned SYMBOLS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire hmm_pkg::in_item_t cmd,
  output logic                   busy,
  output logic                   result_valid,
  output hmm_pkg::out_item_t     result
);

  logic              pop;
  logic              empty;
  hmm_pkg::in_item_t q_data;

  hmm_front #(.STATES(STATES), .SYMBOLS(SYMBOLS)) u_front (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy),
    .pop(pop), .pop_data(q_data), .empty(empty)
  );

  hmm_exec #(.STATES(STATES), .SYMBOLS(SYMBOLS)) u_exec (
    .clk(clk), .rst(rst), .empty(empty), .cmd(q_data), .pop(pop),
    .result_valid(result_valid), .result(result)
  );

endmodule

`default_nettype wire

FILE: rtl/hmm_ram.sv
//------------------------------------------------------------------------------
// hmm_ram
// generic single-port-write, single-port-read ram with registered read
//------------------------------------------------------------------------------
`default_nettype none

module hmm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/hmm_fifo.sv
//------------------------------------------------------------------------------
// hmm_fifo
// short command queue between the front end and the execution engine
//------------------------------------------------------------------------------
`default_nettype none

module hmm_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire hmm_pkg::in_item_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output hmm_pkg::in_item_t      pop_data,
  output logic                   empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  hmm_pkg::in_item_t slots [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;

  assign full     = (count == (AW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hmm_front.sv
//------------------------------------------------------------------------------
// hmm_front
// accepts commands, drops those that do nothing, queues the rest
//------------------------------------------------------------------------------
`default_nettype none

module hmm_front #(
  parameter int unsigned STATES  = 8,
  parameter int unsigned SYMBOLS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire hmm_pkg::in_item_t cmd,
  output logic                   busy,
  input  wire logic              pop,
  output hmm_pkg::in_item_t      pop_data,
  output logic                   empty
);

  logic keep;
  logic full;

  always_comb begin
    unique case (cmd.func)
      hmm_pkg::FN_OBSERVE:  keep = 32'(cmd.symbol) < SYMBOLS;
      hmm_pkg::FN_WR_TRANS: keep = (32'(cmd.row) < STATES) && (32'(cmd.col) < STATES);
      hmm_pkg::FN_WR_EMIS:  keep = (32'(cmd.row) < STATES) && (32'(cmd.col) < SYMBOLS);
      hmm_pkg::FN_WR_PRIOR: keep = 32'(cmd.row) < STATES;
      hmm_pkg::FN_RESTART:  keep = 1'b1;
      default:              keep = 1'b0;
    endcase
  end

  assign busy = full;

  hmm_fifo #(.DEPTH(2)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (start && !full && keep),
    .push_data (cmd),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

endmodule

`default_nettype wire

FILE: rtl/hmm_exec.sv
//------------------------------------------------------------------------------
// hmm_exec
// execution engine: table writes, multiply-accumulate, serial normalization
//------------------------------------------------------------------------------
`default_nettype none

module hmm_exec #(
  parameter int unsigned STATES  = 8,
  parameter int unsigned SYMBOLS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              empty,
  input  wire hmm_pkg::in_item_t cmd,
  output logic                   pop,
  output logic                   result_valid,
  output hmm_pkg::out_item_t     result
);

  localparam int unsigned SW  = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int unsigned TD  = STATES * STATES;
  localparam int unsigned ED  = STATES * SYMBOLS;
  localparam int unsigned TAW = $clog2(TD);
  localparam int unsigned EAW = $clog2(ED);
  localparam int unsigned ACW = 32 + $clog2(STATES);
  localparam int unsigned FW  = ACW + 16;
  localparam int unsigned TW  = FW + $clog2(STATES);
  localparam int unsigned QW  = 17;
  localparam int unsigned SYM_LOC_W = hmm_pkg::SYM_W;

  hmm_pkg::exec_state_t state, state_next;

  logic [SW-1:0] jj;
  logic [SW-1:0] ii;
  logic [SW-1:0] oo;
  logic [15:0]   belief [STATES];
  logic [15:0]   prior  [STATES];
  logic [FW-1:0] fresh  [STATES];
  logic [ACW-1:0] acc;
  logic [31:0]   prod;
  logic [TW-1:0] total;
  logic [SYM_LOC_W-1:0] sym;
  logic          fell;

  // divider
  logic [TW:0]   rem;
  logic [QW-1:0] quo;
  logic [4:0]    bitc;

  logic [15:0]   t_rd;
  logic [15:0]   e_rd;
  logic [TAW-1:0] t_raddr;
  logic [EAW-1:0] e_raddr;
  logic [TAW-1:0] t_waddr;
  logic [EAW-1:0] e_waddr;
  logic           t_we;
  logic           e_we;

  assign t_we    = state == hmm_pkg::ST_IDLE && !empty && cmd.func == hmm_pkg::FN_WR_TRANS;
  assign e_we    = state == hmm_pkg::ST_IDLE && !empty && cmd.func == hmm_pkg::FN_WR_EMIS;
  assign t_waddr = TAW'(32'(cmd.row) * STATES + 32'(cmd.col));
  assign e_waddr = EAW'(32'(cmd.row) * SYMBOLS + 32'(cmd.col));
  assign t_raddr = TAW'(32'(ii) * STATES + 32'(jj));
  assign e_raddr = EAW'(32'(jj) * SYMBOLS + 32'(sym));

  hmm_ram #(.WIDTH(16), .DEPTH(TD)) u_trans (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(cmd.value),
    .raddr(t_raddr), .rdata(t_rd)
  );

  hmm_ram #(.WIDTH(16), .DEPTH(ED)) u_emis (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(cmd.value),
    .raddr(e_raddr), .rdata(e_rd)
  );

  logic [TW:0] rem_sh;
  logic [TW:0] rem_sub;
  assign rem_sh  = {rem[TW-1:0], 1'b0};
  assign rem_sub = rem_sh - {1'b0, total};

  always_comb begin
    state_next = state;
    unique case (state)
      hmm_pkg::ST_IDLE: begin
        if (!empty) begin
          if (cmd.func == hmm_pkg::FN_OBSERVE) begin
            state_next = hmm_pkg::ST_MAC_RD;
          end else if (cmd.func == hmm_pkg::FN_RESTART) begin
            state_next = hmm_pkg::ST_RESTART;
          end
        end
      end
      hmm_pkg::ST_MAC_RD:   state_next = hmm_pkg::ST_MAC_MUL;
      hmm_pkg::ST_MAC_MUL:  state_next = hmm_pkg::ST_MAC_ACC;
      hmm_pkg::ST_MAC_ACC: begin
        state_next = (32'(ii) == STATES-1) ? hmm_pkg::ST_EMIS_RD : hmm_pkg::ST_MAC_RD;
      end
      hmm_pkg::ST_EMIS_RD:  state_next = hmm_pkg::ST_EMIS_MUL;
      hmm_pkg::ST_EMIS_MUL: begin
        state_next = (32'(jj) == STATES-1) ? hmm_pkg::ST_DIV_START : hmm_pkg::ST_MAC_RD;
      end
      hmm_pkg::ST_DIV_START: begin
        state_next = (total == '0) ? hmm_pkg::ST_EMIT : hmm_pkg::ST_DIV_RUN;
      end
      hmm_pkg::ST_DIV_RUN: begin
        if (bitc == 5'd16) begin
          state_next = (32'(jj) == STATES-1) ? hmm_pkg::ST_EMIT : hmm_pkg::ST_DIV_START;
        end
      end
      hmm_pkg::ST_EMIT: begin
        if (32'(oo) == STATES-1) begin
          state_next = hmm_pkg::ST_IDLE;
        end
      end
      hmm_pkg::ST_RESTART:  state_next = hmm_pkg::ST_IDLE;
      default:              state_next = hmm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    unique case (state)
      hmm_pkg::ST_IDLE: begin
        pop = !empty && cmd.func != hmm_pkg::FN_OBSERVE && cmd.func != hmm_pkg::FN_RESTART;
      end
      hmm_pkg::ST_EMIT:    pop = 32'(oo) == STATES-1;
      hmm_pkg::ST_RESTART: pop = 1'b1;
      default:             pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hmm_pkg::ST_IDLE;
      for (int k = 0; k < STATES; k++) begin
        belief[k] <= '0;
      end
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      unique case (state)
        hmm_pkg::ST_IDLE: begin
          ii    <= '0;
          jj    <= '0;
          oo    <= '0;
          acc   <= '0;
          total <= '0;
          sym   <= cmd.symbol;
          if (!empty && cmd.func == hmm_pkg::FN_WR_PRIOR) begin
            prior[SW'(cmd.row)] <= cmd.value;
          end
        end
        hmm_pkg::ST_MAC_RD: ;
        hmm_pkg::ST_MAC_MUL: prod <= 32'(t_rd) * 32'(belief[ii]);
        hmm_pkg::ST_MAC_ACC: begin
          acc <= acc + ACW'(prod);
          if (32'(ii) != STATES-1) begin
            ii <= ii + 1'b1;
          end
        end
        hmm_pkg::ST_EMIS_RD: ;
        hmm_pkg::ST_EMIS_MUL: begin
          fresh[jj] <= FW'(acc) * FW'(e_rd);
          total     <= total + TW'(FW'(acc) * FW'(e_rd));
          acc       <= '0;
          ii        <= '0;
          jj        <= (32'(jj) == STATES-1) ? '0 : jj + 1'b1;
        end
        hmm_pkg::ST_DIV_START: begin
          rem  <= {1'b0, TW'(fresh[jj])};
          quo  <= '0;
          bitc <= '0;
          fell <= (total == '0);
          if (total == '0) begin
            for (int k = 0; k < STATES; k++) begin
              belief[k] <= prior[k];
            end
          end
        end
        hmm_pkg::ST_DIV_RUN: begin
          if (bitc == 5'd16) begin
            belief[jj] <= (quo[16]) ? 16'hFFFF : quo[15:0];
            jj         <= (32'(jj) == STATES-1) ? '0 : jj + 1'b1;
          end else begin
            bitc <= bitc + 1'b1;
            // first quotient bit covers num == den
            if (bitc == 5'd0 && rem[TW-1:0] == total) begin
              rem <= '0;
              quo <= QW'(1) << 16;
            end else if (!rem_sub[TW]) begin
              rem <= rem_sub;
              quo <= quo | (QW'(1) << (5'd15 - bitc));
            end else begin
              rem <= rem_sh;
            end
          end
        end
        hmm_pkg::ST_EMIT: begin
          result_valid        <= 1'b1;
          result.state_index  <= hmm_pkg::IDX_W'(oo);
          result.probability  <= belief[oo];
          result.last         <= 32'(oo) == STATES-1;
          result.fell_back    <= fell;
          oo                  <= (32'(oo) == STATES-1) ? '0 : oo + 1'b1;
        end
        hmm_pkg::ST_RESTART: begin
          for (int k = 0; k < STATES; k++) begin
            belief[k] <= prior[k];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/hmm_filter_checker.sv
//------------------------------------------------------------------------------
// hmm_filter_checker
// watches command and result transfers, keeps its own copy of the model
// tables and belief, predicts each observation's beliefs and compares them
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmm_filter_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  hmm_pkg::in_item_t  cmd,
  input  logic               result_valid,
  input  hmm_pkg::out_item_t result,
  output int                 fail_count,
  output int                 pending
);

  localparam int NS = 8;
  localparam int NSYM = 16;

  logic [15:0]        trans_q[NS*NS];
  logic [15:0]        emis_q[NS*NSYM];
  logic [15:0]        prior_q[NS];
  logic [15:0]        belief_q[NS];
  hmm_pkg::out_item_t belief_expected[$];

  function automatic logic [15:0] norm_belief(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = num / den;
    r = num % den;
    for (int k = 0; k < 16; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return (q > 64'd65535) ? 16'hffff : q[15:0];
  endfunction

  task automatic track_command(hmm_pkg::in_item_t c);
    logic [63:0]        fresh[NS];
    logic [63:0]        acc;
    logic [63:0]        total;
    hmm_pkg::out_item_t r;
    case (c.func)
      hmm_pkg::FN_WR_TRANS: if (c.col < NS) trans_q[c.row*NS + c.col] = c.value;
      hmm_pkg::FN_WR_EMIS:  emis_q[c.row*NSYM + c.col] = c.value;
      hmm_pkg::FN_WR_PRIOR: prior_q[c.row] = c.value;
      hmm_pkg::FN_RESTART:  belief_q = prior_q;
      hmm_pkg::FN_OBSERVE: begin
        total = '0;
        for (int j = 0; j < NS; j++) begin
          acc = '0;
          for (int i = 0; i < NS; i++) acc += trans_q[i*NS + j] * belief_q[i];
          fresh[j] = acc * emis_q[j*NSYM + c.symbol];
          total += fresh[j];
        end
        if (total == '0) belief_q = prior_q;
        else for (int j = 0; j < NS; j++) belief_q[j] = norm_belief(fresh[j], total);
        for (int j = 0; j < NS; j++) begin
          r.state_index = j[2:0];
          r.probability = belief_q[j];
          r.last        = (j == NS-1);
          r.fell_back   = (total == '0);
          belief_expected.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    hmm_pkg::out_item_t e;
    if (rst) begin
      fail_count <= 0;
      for (int i = 0; i < NS; i++) belief_q[i] = '0;
      belief_expected.delete();
    end else begin
      if (result_valid) begin
        if (belief_expected.size() == 0) begin
          $error("unexpected result transfer %p", result);
          fail_count <= fail_count + 1;
        end else begin
          e = belief_expected.pop_front();
          if (result.state_index !== e.state_index) begin
            $error("state_index exp %0d got %0d", e.state_index, result.state_index);
            fail_count <= fail_count + 1;
          end
          if (result.probability !== e.probability) begin
            $error("probability exp %0d got %0d", e.probability, result.probability);
            fail_count <= fail_count + 1;
          end
          if (result.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, result.last);
            fail_count <= fail_count + 1;
          end
          if (result.fell_back !== e.fell_back) begin
            $error("fell_back exp %0d got %0d", e.fell_back, result.fell_back);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) track_command(cmd);
    end
    pending <= belief_expected.size();
  end
endmodule

FILE: tb/sv/tb.sv
//------------------------------------------------------------------------------
// tb
// forward filter step testbench: loads the tables, then runs directed and
// random observations, restarts and writes in bursts; checker does the compare
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int OBS_SYMS = 2;

  logic               clk;
  logic               rst;
  logic               start;
  hmm_pkg::in_item_t  cmd;
  logic               busy;
  logic               result_valid;
  hmm_pkg::out_item_t result;
  int                 fail_count;
  int                 pending;
  int                 gap_left;

  hmm_forward_filter_step dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .result_valid(result_valid), .result(result)
  );

  hmm_filter_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  // one command transfer, with a random gap before it at burst boundaries
  task automatic send(logic [2:0] f, logic [3:0] s, logic [2:0] r,
                      logic [3:0] c, logic [15:0] v);
    int gap;
    if (gap_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 40));
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      gap_left = int'($urandom_range(1, 12));
    end
    gap_left--;
    start <= 1'b1;
    cmd <= '{func: f, symbol: s, row: r, col: c, value: v};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_prob();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // prior one-hot at state 2, transition row 2 keeps only its self loop
  task automatic load_tables();
    for (int i = 0; i < 8; i++) begin
      send(hmm_pkg::FN_WR_PRIOR, 4'($urandom), 3'(i), 4'($urandom),
           (i == 2) ? 16'hffff : 16'h0000);
      for (int j = 0; j < 8; j++)
        send(hmm_pkg::FN_WR_TRANS, 4'($urandom), 3'(i), 4'(j),
             (i != 2) ? rand_prob() : ((j == 2) ? 16'hc000 : 16'h0000));
      for (int s = 0; s < OBS_SYMS; s++)
        send(hmm_pkg::FN_WR_EMIS, 4'($urandom), 3'(i), 4'(s),
             (i == 2 && s == 0) ? 16'h8000 : rand_prob());
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    gap_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_tables();
    // directed: zero belief falls back, single state saturates, ignored codes
    send(hmm_pkg::FN_OBSERVE, 4'd0, 3'd0, 4'd0, 16'h0000);
    send(hmm_pkg::FN_OBSERVE, 4'd0, 3'd7, 4'd15, 16'hffff);
    send(hmm_pkg::FN_RESTART, 4'd0, 3'd0, 4'd0, 16'h0000);
    send(hmm_pkg::FN_OBSERVE, 4'd1, 3'd5, 4'd9, 16'h1234);
    send(hmm_pkg::FN_WR_TRANS, 4'd0, 3'd7, 4'd15, 16'h1234);
    send(3'd5, 4'hf, 3'd7, 4'hf, 16'hffff);
    send(3'd6, 4'd0, 3'd0, 4'd0, 16'h0000);
    send(3'd7, 4'ha, 3'd5, 4'h5, 16'haaaa);
    send(hmm_pkg::FN_OBSERVE, 4'd0, 3'd0, 4'd0, 16'h0000);
    // hold off until every result has come
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 28; n++) begin
      case ($urandom_range(0, 9))
        0: send(hmm_pkg::FN_RESTART, 4'($urandom), 3'($urandom), 4'($urandom),
                16'($urandom));
        1: send(hmm_pkg::FN_WR_TRANS, 4'($urandom), 3'($urandom),
                4'($urandom_range(0, 15)), rand_prob());
        2: send(hmm_pkg::FN_WR_EMIS, 4'($urandom), 3'($urandom), 4'($urandom),
                rand_prob());
        3: send(hmm_pkg::FN_WR_PRIOR, 4'($urandom), 3'($urandom), 4'($urandom),
                rand_prob());
        4: send(3'($urandom_range(5, 7)), 4'($urandom), 3'($urandom), 4'($urandom),
                16'($urandom));
        default: send(hmm_pkg::FN_OBSERVE, 4'($urandom_range(0, OBS_SYMS-1)),
                      3'($urandom), 4'($urandom), 16'($urandom));
      endcase
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
